@@ design/maf_pkg.sv @@
// Package for the multimode audio filter: register and mode codes, fixed widths,
// the echo weight table and the microcode program of the sequencer.
// No dependencies; the filter top level and the testbench import it.
package maf_pkg;

    localparam int ACC_W      = 20;
    localparam int MAX_TAPS   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int IIR_SHIFT  = 7;
    localparam int DIV3_SHIFT = 13;

    localparam logic [11:0] DIV3_MUL       = 12'd2731;
    localparam logic [11:0] ECHO_DELAY_RST = 12'd800;

    localparam logic [1:0] MODE_AVG      = 2'd0;
    localparam logic [1:0] MODE_LOWPASS  = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS = 2'd2;
    localparam logic [1:0] MODE_ECHO     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_COUNT   = 3'd5;

    typedef logic [3:0] t_step;

    localparam t_step ST_WAIT     = 4'd0;
    localparam t_step ST_DISPATCH = 4'd1;
    localparam t_step ST_IIR_A    = 4'd2;
    localparam t_step ST_IIR_B    = 4'd3;
    localparam t_step ST_ECHO_X   = 4'd4;
    localparam t_step ST_TAP_ADDR = 4'd5;
    localparam t_step ST_TAP_READ = 4'd6;
    localparam t_step ST_TAP_MAC  = 4'd7;
    localparam t_step ST_FINISH   = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MAC_IIR_A,
        OP_MAC_IIR_B,
        OP_MAC_ECHO_X,
        OP_ADDR,
        OP_READ,
        OP_MAC_TAP,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_ACCEPT,
        J_MODE,
        J_HOLD_NEG,
        J_LOOP,
        J_OUT_FREE
    } t_jmp;

    typedef struct packed {
        t_op   op;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        unique case (step)
            ST_WAIT:     w = '{op: OP_LOAD,       jmp: J_ACCEPT,   target: ST_DISPATCH};
            ST_DISPATCH: w = '{op: OP_NOP,        jmp: J_MODE,     target: ST_WAIT};
            ST_IIR_A:    w = '{op: OP_MAC_IIR_A,  jmp: J_NEXT,     target: ST_WAIT};
            ST_IIR_B:    w = '{op: OP_MAC_IIR_B,  jmp: J_GOTO,     target: ST_FINISH};
            ST_ECHO_X:   w = '{op: OP_MAC_ECHO_X, jmp: J_NEXT,     target: ST_WAIT};
            ST_TAP_ADDR: w = '{op: OP_ADDR,       jmp: J_NEXT,     target: ST_WAIT};
            ST_TAP_READ: w = '{op: OP_READ,       jmp: J_HOLD_NEG, target: ST_WAIT};
            ST_TAP_MAC:  w = '{op: OP_MAC_TAP,    jmp: J_LOOP,     target: ST_TAP_ADDR};
            ST_FINISH:   w = '{op: OP_FINISH,     jmp: J_OUT_FREE, target: ST_WAIT};
            default:     w = '{op: OP_NOP,        jmp: J_GOTO,     target: ST_WAIT};
        endcase
        return w;
    endfunction

    function automatic t_step mode_entry(input logic [1:0] mode);
        t_step s;
        unique case (mode)
            MODE_AVG:      s = ST_TAP_ADDR;
            MODE_LOWPASS:  s = ST_IIR_A;
            MODE_HIGHPASS: s = ST_IIR_A;
            MODE_ECHO:     s = ST_ECHO_X;
            default:       s = ST_WAIT;
        endcase
        return s;
    endfunction

    // Weight of the echo mix; position 0 is the current sample.
    function automatic logic [7:0] echo_weight(input logic [1:0] taps, input logic [1:0] pos);
        logic [7:0] w;
        unique case ({taps, pos})
            {2'd1, 2'd0}: w = 8'd96;
            {2'd1, 2'd1}: w = 8'd32;
            {2'd2, 2'd0}: w = 8'd64;
            {2'd2, 2'd1}: w = 8'd40;
            {2'd2, 2'd2}: w = 8'd24;
            {2'd3, 2'd0}: w = 8'd44;
            {2'd3, 2'd1}: w = 8'd36;
            {2'd3, 2'd2}: w = 8'd28;
            {2'd3, 2'd3}: w = 8'd20;
            default:      w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

@@ design/multimode_audio_filter.sv @@
// Multimode audio filter: a microcoded sequencer over one shared multiply-accumulate.
// The work per sample grows with the echo tap count and the averaging length, and the
// sequencer spends extra steps on a tap that wraps more than once and at the last step while the
// previous result still waits at the output. Synchronous active-low reset loads register
// defaults and clears history at once through a fill count. Depends on maf_pkg and maf_ram.
module multimode_audio_filter
    import maf_pkg::*;
#(
    parameter int DELAY_DEPTH      = 4096,
    parameter int MAX_AVERAGE_LOG2 = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_dac_code,
    output logic                  o_wrapped,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int TW = ((AW > 12) ? AW : 12) + 2;
    localparam int IW = MAX_AVERAGE_LOG2 + 1;
    localparam logic signed [TW-1:0] DEPTH_S   = TW'(DELAY_DEPTH);
    localparam logic [AW:0]          FILL_FULL = (AW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]        WP_LAST   = AW'(DELAY_DEPTH - 1);

    t_step                   r_step;
    t_step                   n_step;
    logic [1:0]              r_filter_mode;
    logic [1:0]              r_average_log2;
    logic signed [8:0]       r_coef_a;
    logic signed [8:0]       r_coef_b;
    logic [11:0]             r_echo_delay;
    logic [1:0]              r_echo_count;
    logic [AW-1:0]           r_wp;
    logic [AW:0]             r_fill;
    logic signed [7:0]       r_x;
    logic signed [7:0]       r_x1;
    logic signed [7:0]       r_y1;
    logic signed [ACC_W-1:0] r_acc;
    logic [IW-1:0]           r_idx;
    logic [10:0]             r_d3;
    logic signed [TW-1:0]    r_tap;
    logic                    r_tap_ok;
    logic                    r_out_valid;
    logic [7:0]              r_dac;
    logic                    r_wrapped;

    t_uword                  uw;
    logic                    in_acc;
    logic                    out_free;
    logic                    cfg_hit;
    logic                    is_avg;
    logic signed [7:0]       x_in;
    logic [1:0]              taps;
    logic [1:0]              k;
    logic [IW-1:0]           avg_last;
    logic [1:0]              pos;
    logic [1:0]              m;
    logic [11:0]             back;
    logic signed [TW-1:0]    tap_raw;
    logic signed [TW-1:0]    tap_adj;
    logic signed [8:0]       mul_a;
    logic signed [8:0]       mul_b;
    logic signed [17:0]      mul_p;
    logic signed [ACC_W-1:0] acc_sum;
    logic [2:0]              shift;
    logic signed [ACC_W-1:0] y_full;
    logic                    wrap;
    logic                    more;
    logic [23:0]             d3_prod;
    logic [AW-1:0]           wp_next;
    logic [7:0]              ram_rd;
    logic                    ram_rd_en;

    assign uw       = uc_rom(r_step);
    assign in_acc   = i_in_valid && (uw.op == OP_LOAD);
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_hit  = i_cfg_wr_en && (i_cfg_index <= REG_ECHO_COUNT);
    assign is_avg   = (r_filter_mode == MODE_AVG);
    assign x_in     = $signed({~i_adc_sample[7], i_adc_sample[6:0]});

    assign taps = (r_echo_count == 2'd0) ? 2'd1 :
                  (int'(r_echo_count) > MAX_TAPS) ? 2'(MAX_TAPS) : r_echo_count;
    assign k    = (int'(r_average_log2) > MAX_AVERAGE_LOG2) ?
                  2'(MAX_AVERAGE_LOG2) : r_average_log2;
    assign avg_last = (IW'(1) << k) - IW'(1);
    assign pos      = r_idx[1:0];
    assign m        = taps - pos + 2'd1;
    assign more     = is_avg ? (r_idx != avg_last) : (r_idx != IW'(taps));

    always_comb begin
        if (is_avg) begin
            back = 12'(r_idx);
        end else begin
            unique case (m)
                2'd2:    back = {1'b0, r_echo_delay[11:1]};
                2'd3:    back = {1'b0, r_d3};
                default: back = r_echo_delay;
            endcase
        end
    end

    assign tap_raw = $signed(TW'(r_wp)) - $signed(TW'(back));
    assign tap_adj = tap_raw[TW-1] ? tap_raw + DEPTH_S : tap_raw;

    always_comb begin
        unique case (uw.op)
            OP_MAC_IIR_A: begin
                mul_a = r_coef_a;
                mul_b = (r_filter_mode == MODE_LOWPASS) ?
                        $signed({r_x[7], r_x}) + $signed({r_x1[7], r_x1}) :
                        $signed({r_x[7], r_x}) - $signed({r_x1[7], r_x1});
            end
            OP_MAC_IIR_B: begin
                mul_a = r_coef_b;
                mul_b = $signed({r_y1[7], r_y1});
            end
            OP_MAC_ECHO_X: begin
                mul_a = $signed({1'b0, echo_weight(taps, 2'd0)});
                mul_b = $signed({r_x[7], r_x});
            end
            OP_MAC_TAP: begin
                mul_a = is_avg ? 9'sd1 : $signed({1'b0, echo_weight(taps, pos)});
                mul_b = r_tap_ok ? $signed({ram_rd[7], ram_rd}) : 9'sd0;
            end
            default: begin
                mul_a = 9'sd0;
                mul_b = 9'sd0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_acc + ACC_W'(mul_p);
    assign shift   = is_avg ? {1'b0, k} : 3'(IIR_SHIFT);
    assign y_full  = r_acc >>> shift;
    assign wrap    = (y_full[ACC_W-1:7] != {(ACC_W - 7){y_full[7]}});
    assign d3_prod = r_echo_delay * DIV3_MUL;
    assign wp_next = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);

    always_comb begin
        unique case (uw.jmp)
            J_NEXT:     n_step = r_step + t_step'(1);
            J_GOTO:     n_step = uw.target;
            J_ACCEPT:   n_step = in_acc ? uw.target : r_step;
            J_MODE:     n_step = mode_entry(r_filter_mode);
            J_HOLD_NEG: n_step = r_tap[TW-1] ? r_step : r_step + t_step'(1);
            J_LOOP:     n_step = more ? uw.target : r_step + t_step'(1);
            J_OUT_FREE: n_step = out_free ? uw.target : r_step;
            default:    n_step = ST_WAIT;
        endcase
    end

    assign ram_rd_en = (uw.op == OP_READ) && !r_tap[TW-1];

    maf_ram #(
        .WIDTH(8),
        .DEPTH(DELAY_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (in_acc),
        .i_wr_addr(r_wp),
        .i_wr_data(x_in),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(r_tap[AW-1:0]),
        .o_rd_data(ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= ST_WAIT;
            r_out_valid    <= 1'b0;
            r_filter_mode  <= MODE_AVG;
            r_average_log2 <= 2'd1;
            r_coef_a       <= '0;
            r_coef_b       <= '0;
            r_echo_delay   <= ECHO_DELAY_RST;
            r_echo_count   <= 2'd1;
            r_wp           <= '0;
            r_fill         <= '0;
            r_x1           <= '0;
            r_y1           <= '0;
        end else begin
            r_step <= n_step;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (uw.op)
                OP_LOAD: begin
                    if (in_acc) begin
                        r_x   <= x_in;
                        r_acc <= '0;
                        r_idx <= '0;
                        if (r_fill != FILL_FULL) begin
                            r_fill <= r_fill + (AW + 1)'(1);
                        end
                    end
                end
                OP_MAC_IIR_A, OP_MAC_IIR_B: begin
                    r_acc <= acc_sum;
                end
                OP_MAC_ECHO_X: begin
                    r_acc <= acc_sum;
                    r_idx <= IW'(1);
                    r_d3  <= d3_prod[23:DIV3_SHIFT];
                end
                OP_ADDR: begin
                    r_tap <= tap_adj;
                end
                OP_READ: begin
                    if (r_tap[TW-1]) begin
                        r_tap <= r_tap + DEPTH_S;
                    end else begin
                        r_tap_ok <= ($unsigned(r_tap) < TW'(r_fill));
                    end
                end
                OP_MAC_TAP: begin
                    r_acc <= acc_sum;
                    r_idx <= r_idx + IW'(1);
                end
                OP_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_dac       <= {~y_full[7], y_full[6:0]};
                        r_wrapped   <= wrap;
                        r_x1        <= r_x;
                        r_y1        <= y_full[7:0];
                        r_wp        <= wp_next;
                    end
                end
                default: begin
                end
            endcase
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    REG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[1:0];
                    REG_AVERAGE_LOG2: r_average_log2 <= i_cfg_data[1:0];
                    REG_COEF_A:       r_coef_a       <= $signed(i_cfg_data[8:0]);
                    REG_COEF_B:       r_coef_b       <= $signed(i_cfg_data[8:0]);
                    REG_ECHO_DELAY:   r_echo_delay   <= i_cfg_data;
                    REG_ECHO_COUNT:   r_echo_count   <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
                r_wp   <= '0;
                r_fill <= '0;
                r_x1   <= '0;
                r_y1   <= '0;
            end
        end
    end

    assign o_in_ready  = (uw.op == OP_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_dac_code  = r_dac;
    assign o_wrapped   = r_wrapped;

endmodule

@@ design/maf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module maf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/maf_checker.sv @@
// Port-level checker for the multimode audio filter and its bind statement.
// Depends on the top level multimode_audio_filter.
module maf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_dac_code,
    input logic       o_wrapped,
    input logic       i_cfg_wr_en
);

    // A result waiting at the output keeps its value until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_dac_code) && $stable(o_wrapped))
        else $error("output transaction changed before it was taken");

    // After a sample is taken the sequencer is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted in two consecutive cycles");

    // A new result only appears when the block was busy computing just before it rose.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a computation");

    // A register write while idle and with no sample offered leaves the block idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && o_in_ready && !i_in_valid |=> o_in_ready)
        else $error("register write started the sequencer");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind multimode_audio_filter maf_checker u_maf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_dac_code  (o_dac_code),
    .o_wrapped   (o_wrapped),
    .i_cfg_wr_en (i_cfg_wr_en)
);

@@ tb/sv/multimode_audio_filter_test.sv @@
// Self-checking testbench for the multimode audio filter: random bursty stimulus,
// random output back-pressure and a predictor of every DAC code and wrap flag.
// Depends on maf_pkg and the multimode_audio_filter RTL.
module multimode_audio_filter_test;
    import maf_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HIST_DEPTH    = 4096;
    localparam int TAIL_CYCLES   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] code;
        logic       wrap;
    } t_dac_result;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [7:0]            i_adc_sample = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [7:0]            o_dac_code;
    logic                  o_wrapped;

    // Filter settings and history as the predictor sees them.
    logic [1:0]         cfg_mode;
    logic [1:0]         cfg_avg_log2;
    logic signed [8:0]  cfg_coef_a;
    logic signed [8:0]  cfg_coef_b;
    logic [11:0]        cfg_echo_delay;
    logic [1:0]         cfg_echo_count;
    logic signed [7:0]  sample_hist [HIST_DEPTH];
    logic [11:0]        hist_ptr;
    logic signed [7:0]  prev_in;
    logic signed [7:0]  prev_out;

    logic [7:0]   sample_queue [$];
    t_dac_result  dac_expect [$];
    logic         in_accepted = 1'b0;
    bit           calm = 1'b0;
    int           samples_sent = 0;
    int           samples_taken = 0;
    int           results_seen = 0;
    int           wraps_seen = 0;
    int           reg_writes = 0;
    int           errors = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           ready_run = 0;
    int           stall_run = 0;

    multimode_audio_filter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_adc_sample (i_adc_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dac_code   (o_dac_code),
        .o_wrapped    (o_wrapped),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int mix_weight(input int taps, input int pos);
        int w;
        case ({taps[1:0], pos[1:0]})
            {2'd1, 2'd0}: w = 96;
            {2'd1, 2'd1}: w = 32;
            {2'd2, 2'd0}: w = 64;
            {2'd2, 2'd1}: w = 40;
            {2'd2, 2'd2}: w = 24;
            {2'd3, 2'd0}: w = 44;
            {2'd3, 2'd1}: w = 36;
            {2'd3, 2'd2}: w = 28;
            {2'd3, 2'd3}: w = 20;
            default:      w = 0;
        endcase
        return w;
    endfunction

    task automatic clear_history();
        foreach (sample_hist[i]) sample_hist[i] = '0;
        hist_ptr = '0;
        prev_in  = '0;
        prev_out = '0;
    endtask

    task automatic filter_step(input logic [7:0] adc, output t_dac_result res);
        int x;
        int y;
        int acc;
        int taps;
        int lag;
        int i;
        x = int'(adc) - 128;
        sample_hist[hist_ptr] = x[7:0];
        case (cfg_mode)
            MODE_AVG: begin
                acc = 0;
                for (i = 0; i < (1 << cfg_avg_log2); i++) begin
                    acc += int'(sample_hist[hist_ptr - 12'(i)]);
                end
                y = acc >>> cfg_avg_log2;
            end
            MODE_LOWPASS: begin
                y = (int'(cfg_coef_a) * (x + int'(prev_in))
                    + int'(cfg_coef_b) * int'(prev_out)) >>> IIR_SHIFT;
            end
            MODE_HIGHPASS: begin
                y = (int'(cfg_coef_a) * (x - int'(prev_in))
                    + int'(cfg_coef_b) * int'(prev_out)) >>> IIR_SHIFT;
            end
            default: begin
                taps = (cfg_echo_count == 2'd0) ? 1 : int'(cfg_echo_count);
                acc = mix_weight(taps, 0) * x;
                for (i = 1; i <= taps; i++) begin
                    lag = int'(cfg_echo_delay) / (taps - i + 1);
                    acc += mix_weight(taps, i) * int'(sample_hist[hist_ptr - 12'(lag)]);
                end
                y = acc >>> IIR_SHIFT;
            end
        endcase
        hist_ptr = hist_ptr + 12'd1;
        prev_in  = x[7:0];
        prev_out = y[7:0];
        res.code = 8'(y + 128);
        res.wrap = (y < -128) || (y > 127);
    endtask

    // Predictor update and result checking.
    always @(posedge i_clk) begin
        t_dac_result want;
        t_dac_result got;
        if (!i_rst_n) begin
            cfg_mode       = MODE_AVG;
            cfg_avg_log2   = 2'd1;
            cfg_coef_a     = '0;
            cfg_coef_b     = '0;
            cfg_echo_delay = ECHO_DELAY_RST;
            cfg_echo_count = 2'd1;
            clear_history();
            in_accepted <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_FILTER_MODE:  cfg_mode       = i_cfg_data[1:0];
                    REG_AVERAGE_LOG2: cfg_avg_log2   = i_cfg_data[1:0];
                    REG_COEF_A:       cfg_coef_a     = i_cfg_data[8:0];
                    REG_COEF_B:       cfg_coef_b     = i_cfg_data[8:0];
                    REG_ECHO_DELAY:   cfg_echo_delay = i_cfg_data[11:0];
                    REG_ECHO_COUNT:   cfg_echo_count = i_cfg_data[1:0];
                    default: ;
                endcase
                if (i_cfg_index <= REG_ECHO_COUNT) clear_history();
            end
            if (o_out_valid && i_out_ready) begin
                got = '{code: o_dac_code, wrap: o_wrapped};
                results_seen++;
                if (got.wrap) wraps_seen++;
                if (dac_expect.size() == 0) begin
                    $error("Unexpected result transaction: dac_code %0d, wrapped %0d",
                           got.code, got.wrap);
                    errors++;
                end else begin
                    want = dac_expect.pop_front();
                    if (got.code !== want.code) begin
                        $error("dac_code: expected %0d, actual %0d", want.code, got.code);
                        errors++;
                    end
                    if (got.wrap !== want.wrap) begin
                        $error("wrapped: expected %0d, actual %0d", want.wrap, got.wrap);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                filter_step(i_adc_sample, want);
                dac_expect.push_back(want);
                samples_taken++;
            end
            in_accepted <= i_in_valid && o_in_ready;
        end
    end

    // Sample driver: bursts of random length separated by random gaps, with no gaps in calm phases.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepted) begin
            if (gap_left > 0 && !calm) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                i_adc_sample <= sample_queue.pop_front();
                i_in_valid   <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: stall stretches followed by ready stretches; always ready in calm phases.
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_ready <= 1'b1;
        end else begin
            if (ready_run == 0) begin
                ready_run = $urandom_range(1, 8);
                stall_run = $urandom_range(0, 5);
            end
            if (stall_run > 0) begin
                stall_run--;
                i_out_ready <= 1'b0;
            end else begin
                ready_run--;
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send(input logic [7:0] adc);
        sample_queue.push_back(adc);
        samples_sent++;
    endtask

    // The block is idle once every sample has been taken, every result has come
    // back and the sequencer is ready for a new sample.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_taken != samples_sent || dac_expect.size() != 0 || !o_in_ready);
    endtask

    function automatic logic [7:0] pick_sample();
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [8:0] pick_coef();
        case ($urandom_range(0, 3))
            0:       return 9'h100;
            1:       return 9'h0FF;
            default: return 9'($urandom);
        endcase
    endfunction

    initial begin
        int random_left;
        int phase_len;
        int taps;
        logic [1:0] mode;
        logic [11:0] delay;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset settings: two-sample moving average on cleared history.
        send(8'hFF); send(8'h00); send(8'h80); send(8'h7F);
        wait_idle();
        // Writes to unused indexes must leave the history alone.
        write_reg(REG_SPARE_6, 12'hFFF);
        write_reg(REG_SPARE_7, 12'h000);
        send(8'h01); send(8'hFE);
        wait_idle();
        write_reg(REG_AVERAGE_LOG2, 12'h000);
        send(8'hC8); send(8'h03);
        wait_idle();
        write_reg(REG_AVERAGE_LOG2, 12'hFFF);
        send(8'h00); send(8'hFF);
        wait_idle();
        // Largest positive and negative coefficients drive the IIR out of range.
        write_reg(REG_FILTER_MODE, {10'd0, MODE_LOWPASS});
        write_reg(REG_COEF_A, 12'h0FF);
        write_reg(REG_COEF_B, 12'h0FF);
        send(8'hFF); send(8'hFF); send(8'h00);
        wait_idle();
        write_reg(REG_FILTER_MODE, {10'd0, MODE_HIGHPASS});
        write_reg(REG_COEF_A, 12'h100);
        write_reg(REG_COEF_B, 12'h100);
        send(8'hFF); send(8'h00); send(8'hFF);
        wait_idle();
        // Echo with a zero tap count and zero delay, then taps that hit the
        // current sample, then the longest delay.
        write_reg(REG_FILTER_MODE, {10'd0, MODE_ECHO});
        write_reg(REG_ECHO_COUNT, 12'h000);
        write_reg(REG_ECHO_DELAY, 12'h000);
        send(8'h0A); send(8'hFA);
        wait_idle();
        write_reg(REG_ECHO_COUNT, 12'h003);
        write_reg(REG_ECHO_DELAY, 12'h002);
        send(8'h00); send(8'hFF); send(8'h80);
        wait_idle();
        write_reg(REG_ECHO_COUNT, 12'h002);
        write_reg(REG_ECHO_DELAY, 12'hFFF);
        send(8'hFF); send(8'h00);
        wait_idle();

        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            mode = 2'($urandom_range(0, 3));
            write_reg(REG_FILTER_MODE, {10'($urandom), mode});
            case (mode)
                MODE_AVG: begin
                    write_reg(REG_AVERAGE_LOG2, {10'($urandom), 2'($urandom_range(0, 3))});
                end
                MODE_LOWPASS, MODE_HIGHPASS: begin
                    write_reg(REG_COEF_A, {3'($urandom), pick_coef()});
                    write_reg(REG_COEF_B, {3'($urandom), pick_coef()});
                end
                default: begin
                    taps = $urandom_range(0, 3);
                    if ($urandom_range(0, 5) == 0) delay = 12'($urandom_range(41, 4095));
                    else delay = 12'($urandom_range(0, 40));
                    write_reg(REG_ECHO_COUNT, {10'($urandom), 2'(taps)});
                    write_reg(REG_ECHO_DELAY, delay);
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
                          12'($urandom));
            end
            calm = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(15, 50);
            repeat (phase_len) send(pick_sample());
            random_left -= phase_len;
            wait_idle();
        end

        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d samples through %0d register writes across the filter modes.",
                 samples_taken, reg_writes);
        $display("Checked %0d results, %0d of them wrapped, in %0d cycles.",
                 results_seen, wraps_seen, cycle_count);
        if (errors == 0 && dac_expect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ multimode_audio_filter.f @@
design/maf_pkg.sv
design/maf_ram.sv
design/multimode_audio_filter.sv
design/maf_checker.sv
tb/sv/multimode_audio_filter_test.sv
